### rtl/shell_sort_shift_counter_core_assert.svh
// Assertion macros used by the checker file sssc_checker.sv.
`ifndef SHELL_SORT_SHIFT_COUNTER_CORE_ASSERT_SVH
`define SHELL_SORT_SHIFT_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sssc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sssc assertion failed");

`endif

### rtl/sssc_pkg.sv
// ----------------------------------------------------------------------------
// sssc_pkg
// Constants, types and state codes of the Shell sort shift counter.
// ----------------------------------------------------------------------------
package sssc_pkg;

    localparam int unsigned MAX_ELEMENTS = 64;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned SHIFT_W      = 16;
    localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOLD,
        ST_CMP,
        ST_PUT,
        ST_DONE
    } state_t;

    // One access pair to the value store per cycle
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

endpackage

### rtl/sssc_if.sv
// ----------------------------------------------------------------------------
// sssc_in_if / sssc_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface sssc_in_if;
    import sssc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last_element;
    logic                      empty_set;

    modport source (output valid, output element_value, output last_element,
                    output empty_set, input ready);
    modport sink   (input valid, input element_value, input last_element,
                    input empty_set, output ready);
endinterface

interface sssc_out_if;
    import sssc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SHIFT_W-1:0] shift_count;
    logic               overflow;

    modport source (output valid, output shift_count, output overflow, input ready);
    modport sink   (input valid, input shift_count, input overflow, output ready);
endinterface

### rtl/sssc_store.sv
// ----------------------------------------------------------------------------
// sssc_store
// Value store: one write and one registered read per cycle, write-first.
// ----------------------------------------------------------------------------
module sssc_store (
    input  logic                        clk,
    input  sssc_pkg::mem_req_t          req,
    output logic [sssc_pkg::VALUE_W-1:0] rdata
);
    import sssc_pkg::*;

    logic [VALUE_W-1:0] mem_reg [MAX_ELEMENTS];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        // forward a write to the same entry
        if (req.we && (req.waddr == req.raddr))
        begin
            rdata_reg <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sssc_ctrl.sv
// ----------------------------------------------------------------------------
// sssc_ctrl
// Load sequencer, gapped insertion sort over the store, result register.
// ----------------------------------------------------------------------------
module sssc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    sssc_in_if.sink                      in_ch,
    sssc_out_if.source                   out_ch,
    output sssc_pkg::mem_req_t           mem_req,
    input  logic [sssc_pkg::VALUE_W-1:0] rdata
);
    import sssc_pkg::*;

    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [SHIFT_W-1:0] shift_reg,     shift_next;
    logic               drop_reg,      drop_next;
    logic [CNT_W-1:0]   gap_reg,       gap_next;
    logic [CNT_W-1:0]   i_reg,         i_next;
    logic [CNT_W-1:0]   j_reg,         j_next;
    logic [VALUE_W-1:0] held_reg,      held_next;
    logic               out_valid_reg, out_valid_next;
    logic [SHIFT_W-1:0] out_count_reg, out_count_next;
    logic               out_ovf_reg,   out_ovf_next;

    logic               has_room;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   n_load;
    logic [CNT_W-1:0]   gap_load;
    logic [CNT_W-1:0]   i_inc;
    logic [CNT_W-1:0]   gap_half;
    logic [CNT_W-1:0]   j_dn;
    logic [CNT_W-1:0]   j_dn2;
    logic               rd_gt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            drop_reg      <= 1'b0;
            gap_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            drop_reg      <= drop_next;
            gap_reg       <= gap_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        has_room  = (count_reg < CNT_W'(MAX_ELEMENTS));
        count_inc = count_reg + CNT_W'(1);
        n_load    = has_room ? count_inc : count_reg;
        gap_load  = n_load >> 1;
        i_inc     = i_reg + CNT_W'(1);
        gap_half  = gap_reg >> 1;
        j_dn      = j_reg - gap_reg;
        j_dn2     = j_dn - gap_reg;
        rd_gt     = ($signed(rdata) > $signed(held_reg));

        state_next     = state_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        drop_next      = drop_reg;
        gap_next       = gap_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        held_next      = held_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        in_ch.ready    = 1'b0;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.empty_set)
                    begin
                        shift_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (has_room)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = count_reg[IDX_W-1:0];
                            mem_req.wdata = in_ch.element_value;
                            count_next    = count_inc;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        if (in_ch.last_element)
                        begin
                            shift_next    = '0;
                            count_next    = n_load;
                            gap_next      = gap_load;
                            i_next        = gap_load;
                            mem_req.raddr = gap_load[IDX_W-1:0];
                            state_next    = (gap_load == '0) ? ST_DONE : ST_HOLD;
                        end
                    end
                end
            end

            ST_HOLD:
            begin
                // element i arrives; fetch its lower neighbor one gap away
                held_next     = rdata;
                j_next        = i_reg;
                mem_req.raddr = IDX_W'(i_reg - gap_reg);
                state_next    = ST_CMP;
            end

            ST_CMP:
            begin
                if (rd_gt)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = j_reg[IDX_W-1:0];
                    mem_req.wdata = rdata;
                    if (shift_reg != '1)
                    begin
                        shift_next = shift_reg + SHIFT_W'(1);
                    end
                    j_next = j_dn;
                    if (j_dn >= gap_reg)
                    begin
                        mem_req.raddr = j_dn2[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = j_reg[IDX_W-1:0];
                    mem_req.wdata = held_reg;
                    if (i_inc < count_reg)
                    begin
                        i_next        = i_inc;
                        mem_req.raddr = i_inc[IDX_W-1:0];
                        state_next    = ST_HOLD;
                    end
                    else if (gap_half == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        gap_next      = gap_half;
                        i_next        = gap_half;
                        mem_req.raddr = gap_half[IDX_W-1:0];
                        state_next    = ST_HOLD;
                    end
                end
            end

            ST_PUT:
            begin
                // insertion reached the low end of the chain
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg[IDX_W-1:0];
                mem_req.wdata = held_reg;
                if (i_inc < count_reg)
                begin
                    i_next        = i_inc;
                    mem_req.raddr = i_inc[IDX_W-1:0];
                    state_next    = ST_HOLD;
                end
                else if (gap_half == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    gap_next      = gap_half;
                    i_next        = gap_half;
                    mem_req.raddr = gap_half[IDX_W-1:0];
                    state_next    = ST_HOLD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = shift_reg;
                    out_ovf_next   = drop_reg;
                    count_next     = '0;
                    shift_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.shift_count = out_count_reg;
    assign out_ch.overflow    = out_ovf_reg;

endmodule

### rtl/shell_sort_shift_counter_core.sv
// ----------------------------------------------------------------------------
// shell_sort_shift_counter_core
// Collects signed values, Shell sorts them with halving gaps, reports shifts.
// ----------------------------------------------------------------------------
// channel  | dir | payload                                   | item
// ---------+-----+-------------------------------------------+------------------
// in_ch    | in  | element_value[31:0] s, last_element, empty | one value / marker
// out_ch   | out | shift_count[15:0], overflow               | one result per set
//
// Loading takes one item per cycle, one store write each while the store has room.
// After the last item the sort owns the store: each insertion step passes
// through ST_HOLD, one ST_CMP per shift, and then a closing ST_CMP, or ST_PUT
// when it reaches the low end of its chain; ST_DONE hands the result over.
// The single read and single write port of the store make each shift a step.
// The result is registered; a waiting result does not block loading.
// Reset clears the set state; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module shell_sort_shift_counter_core (
    input  logic       clk,
    input  logic       rst_n,
    sssc_in_if.sink    in_ch,
    sssc_out_if.source out_ch
);
    import sssc_pkg::*;

    mem_req_t           mem_req;
    logic [VALUE_W-1:0] rdata;

    sssc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    sssc_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

### rtl/sssc_checker.sv
// ----------------------------------------------------------------------------
// sssc_checker
// Port-level checks of the shift counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "shell_sort_shift_counter_core_assert.svh"

module sssc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_last,
    input logic                         in_empty,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sssc_pkg::SHIFT_W-1:0] shift_count,
    input logic                         overflow
);
    import sssc_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    `SSSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SSSC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(shift_count) && $stable(overflow))
    // sort phase holds off input right after the last item
    `SSSC_ASSERT_NEXT(a_sort_stall, in_acc && in_last && !in_empty, !in_ready)
    // empty item taken while no result waits gives a zero result via ST_DONE
    `SSSC_ASSERT_NEXT(a_empty_res, in_acc && in_empty && !out_valid, ##1 (out_valid && shift_count == SHIFT_W'(0) && !overflow))

endmodule

bind shell_sort_shift_counter_core sssc_checker u_sssc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_last     (in_ch.last_element),
    .in_empty    (in_ch.empty_set),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .shift_count (out_ch.shift_count),
    .overflow    (out_ch.overflow)
);
